FILE: sv/pinned_lru_object_cache_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pinned LRU object cache
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PINNED_LRU_OBJECT_CACHE_DEFINES_SVH
`define PINNED_LRU_OBJECT_CACHE_DEFINES_SVH

// Same-cycle implication
`define PLRU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plru check failed");

// Next-cycle implication
`define PLRU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plru check failed");

`endif

FILE: sv/plru_pkg.sv
// ----------------------------------------------------------------------------
// plru_pkg
// Sizes, entry layout, codes and sequencer states of the LRU object cache.
// ----------------------------------------------------------------------------
package plru_pkg;

  localparam int SLOTS    = 32;
  localparam int KEY_BITS = 32;
  localparam int PIN_BITS = 16;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int NIL_W    = SLOT_W + 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int MAXU_W   = 6;

  localparam logic [NIL_W-1:0]    NIL     = NIL_W'(SLOTS);
  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

  // input modes
  localparam logic [1:0] MODE_GET     = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_DIRTY   = 2'd2;
  localparam logic [1:0] MODE_FLUSH   = 2'd3;

  // result status codes
  localparam logic [3:0] ST_HIT       = 4'd0;
  localparam logic [3:0] ST_LOADED    = 4'd1;
  localparam logic [3:0] ST_ABSENT    = 4'd2;
  localparam logic [3:0] ST_FULL      = 4'd3;
  localparam logic [3:0] ST_BAD       = 4'd4;
  localparam logic [3:0] ST_NOTPIN    = 4'd5;
  localparam logic [3:0] ST_OVERFLOW  = 4'd6;
  localparam logic [3:0] ST_DONE      = 4'd7;
  localparam logic [3:0] ST_WRITEBACK = 4'd8;
  localparam logic [3:0] ST_EVICTED   = 4'd9;

  // configuration register indexes
  localparam logic REG_MAX_UNPINNED = 1'b0;
  localparam logic REG_SAVE_ENABLED = 1'b1;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [PIN_BITS-1:0] pin;
    logic                dirty;
    logic [NIL_W-1:0]    prev;
    logic [NIL_W-1:0]    next;
  } entry_t;

  typedef struct packed {
    logic [3:0]          status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_BITS-1:0] key;
    logic                load;
    logic                evicted;
    logic                last;
  } res_t;

  typedef struct packed {
    logic [MAXU_W-1:0] max_unpinned;
    logic              save_enabled;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_G_SCAN, S_G_DECIDE, S_G_PINW,
    S_REM_P, S_REM_PW, S_REM_N, S_REM_NW, S_REM_END,
    S_H_RD, S_H_CHK, S_ADD_RD, S_ADD_HW, S_ADD_END,
    S_EV_CHK, S_EV_RD, S_F_RD, S_F_CHK, S_EMIT
  } state_t;

endpackage

FILE: sv/plru_entry_ram.sv
// ----------------------------------------------------------------------------
// plru_entry_ram
// Slot entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module plru_entry_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [plru_pkg::SLOT_W-1:0] waddr,
  input  plru_pkg::entry_t            wdata,
  input  logic                        re,
  input  logic [plru_pkg::SLOT_W-1:0] raddr,
  output plru_pkg::entry_t            rdata
);

  plru_pkg::entry_t mem [plru_pkg::SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/plru_engine.sv
// ----------------------------------------------------------------------------
// plru_engine
// Sequencer over the entry store: scan, LRU list edits, evictions, results.
// ----------------------------------------------------------------------------
`include "pinned_lru_object_cache_defines.svh"

module plru_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  plru_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic [plru_pkg::KEY_BITS-1:0] key,
  input  logic [plru_pkg::SLOT_W-1:0]   handle,
  input  logic                          present,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    status,
  output logic [plru_pkg::SLOT_W-1:0]   slot,
  output logic [plru_pkg::KEY_BITS-1:0] entry_key,
  output logic                          load_request,
  output logic                          evicted,
  output logic                          last,
  output logic [plru_pkg::CNT_W-1:0]    entries_in_use,
  output logic [plru_pkg::CNT_W-1:0]    unpinned_count
);

  localparam int SW = plru_pkg::SLOT_W;
  localparam int NW = plru_pkg::NIL_W;
  localparam int CW = plru_pkg::CNT_W;

  plru_pkg::state_t state, state_next, ret;

  // item registers
  logic [1:0]                    mode_r;
  logic [plru_pkg::KEY_BITS-1:0] key_r, hkey;
  logic [SW-1:0]                 h_r;
  logic                          present_r;

  // scan and list registers
  logic [NW-1:0]        idx;
  logic                 chk;
  logic [SW-1:0]        chk_idx;
  logic                 hit_found, free_found;
  logic [SW-1:0]        hit_idx, free_idx, cur;
  plru_pkg::entry_t     ent;
  logic [NW-1:0]        head, tail;
  logic [CW-1:0]        used, unp, fin_used, fin_unp, ev_left;
  logic [plru_pkg::SLOTS-1:0] valid;
  plru_pkg::res_t       pend;

  // memory port
  logic             re, we;
  logic [SW-1:0]    raddr, waddr;
  plru_pkg::entry_t wdata, rdata;

  // release arithmetic
  logic [plru_pkg::PIN_BITS-1:0] pin_dec;
  logic [CW-1:0]                 unp_new, ev_cnt;
  logic                          out_free, idx_end, save_on;

  plru_entry_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  assign pin_dec  = rdata.pin - 1'b1;
  assign unp_new  = unp + 1'b1;
  assign ev_cnt   = (unp_new > CW'(cfg.max_unpinned)) ? unp_new - CW'(cfg.max_unpinned) : '0;
  assign out_free = !out_valid || out_ready;
  assign idx_end  = (idx == NW'(plru_pkg::SLOTS));
  assign save_on  = cfg.save_enabled;
  assign in_ready = (state == plru_pkg::S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      plru_pkg::S_IDLE: begin
        if (in_valid) begin
          case (mode)
            plru_pkg::MODE_GET:   state_next = plru_pkg::S_G_SCAN;
            plru_pkg::MODE_FLUSH: state_next = plru_pkg::S_F_RD;
            default: state_next = valid[handle] ? plru_pkg::S_H_RD : plru_pkg::S_EMIT;
          endcase
        end
      end
      plru_pkg::S_G_SCAN:   if (idx_end && !chk) state_next = plru_pkg::S_G_DECIDE;
      plru_pkg::S_G_DECIDE: begin
        if (!hit_found || ent.pin == plru_pkg::PIN_MAX) state_next = plru_pkg::S_EMIT;
        else if (ent.pin == '0) state_next = plru_pkg::S_REM_P;
        else state_next = plru_pkg::S_G_PINW;
      end
      plru_pkg::S_REM_P:  state_next = (ent.prev < plru_pkg::NIL) ? plru_pkg::S_REM_PW
                                                                   : plru_pkg::S_REM_N;
      plru_pkg::S_REM_PW: state_next = plru_pkg::S_REM_N;
      plru_pkg::S_REM_N:  state_next = (ent.next < plru_pkg::NIL) ? plru_pkg::S_REM_NW
                                                                   : plru_pkg::S_REM_END;
      plru_pkg::S_REM_NW: state_next = plru_pkg::S_REM_END;
      plru_pkg::S_REM_END: state_next = (mode_r == plru_pkg::MODE_GET) ? plru_pkg::S_G_PINW
                                                                        : plru_pkg::S_EMIT;
      plru_pkg::S_G_PINW: state_next = plru_pkg::S_EMIT;
      plru_pkg::S_H_RD:   state_next = plru_pkg::S_H_CHK;
      plru_pkg::S_H_CHK: begin
        if (mode_r == plru_pkg::MODE_DIRTY || rdata.pin == '0 || pin_dec != '0)
          state_next = plru_pkg::S_EMIT;
        else if (head < plru_pkg::NIL) state_next = plru_pkg::S_ADD_RD;
        else state_next = plru_pkg::S_ADD_END;
      end
      plru_pkg::S_ADD_RD:  state_next = plru_pkg::S_ADD_HW;
      plru_pkg::S_ADD_HW:  state_next = plru_pkg::S_ADD_END;
      plru_pkg::S_ADD_END: state_next = plru_pkg::S_EV_CHK;
      plru_pkg::S_EV_CHK:  state_next = (ev_left != '0) ? plru_pkg::S_EV_RD : plru_pkg::S_EMIT;
      plru_pkg::S_EV_RD:   state_next = plru_pkg::S_REM_P;
      plru_pkg::S_F_RD: begin
        if (idx_end) state_next = plru_pkg::S_EMIT;
        else if (valid[idx[SW-1:0]] && save_on) state_next = plru_pkg::S_F_CHK;
      end
      plru_pkg::S_F_CHK: state_next = rdata.dirty ? plru_pkg::S_EMIT : plru_pkg::S_F_RD;
      plru_pkg::S_EMIT:  if (out_free) state_next = ret;
      default: state_next = plru_pkg::S_IDLE;
    endcase
  end

  // memory port drive
  always_comb begin
    re    = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    case (state)
      plru_pkg::S_G_SCAN: begin
        re    = !idx_end;
        raddr = idx[SW-1:0];
      end
      plru_pkg::S_G_DECIDE: begin
        we    = !hit_found && present_r && free_found;
        waddr = free_idx;
        wdata = '{key: key_r, pin: plru_pkg::PIN_BITS'(1), dirty: 1'b0,
                  prev: plru_pkg::NIL, next: plru_pkg::NIL};
      end
      plru_pkg::S_G_PINW: begin
        we    = 1'b1;
        waddr = hit_idx;
        wdata = '{key: ent.key, pin: ent.pin + 1'b1, dirty: ent.dirty,
                  prev: plru_pkg::NIL, next: plru_pkg::NIL};
      end
      plru_pkg::S_REM_P: begin
        re    = ent.prev < plru_pkg::NIL;
        raddr = ent.prev[SW-1:0];
      end
      plru_pkg::S_REM_PW: begin
        we         = 1'b1;
        waddr      = ent.prev[SW-1:0];
        wdata.next = ent.next;
      end
      plru_pkg::S_REM_N: begin
        re    = ent.next < plru_pkg::NIL;
        raddr = ent.next[SW-1:0];
      end
      plru_pkg::S_REM_NW: begin
        we         = 1'b1;
        waddr      = ent.next[SW-1:0];
        wdata.prev = ent.prev;
      end
      plru_pkg::S_H_RD: begin
        re    = 1'b1;
        raddr = h_r;
      end
      plru_pkg::S_H_CHK: begin
        waddr = h_r;
        if (mode_r == plru_pkg::MODE_DIRTY) begin
          we          = 1'b1;
          wdata.dirty = 1'b1;
        end else if (rdata.pin != '0) begin
          we        = 1'b1;
          wdata.pin = pin_dec;
          if (pin_dec == '0) begin
            wdata.prev = plru_pkg::NIL;
            wdata.next = head;
          end
        end
      end
      plru_pkg::S_ADD_RD: begin
        re    = 1'b1;
        raddr = head[SW-1:0];
      end
      plru_pkg::S_ADD_HW: begin
        we         = 1'b1;
        waddr      = head[SW-1:0];
        wdata.prev = {1'b0, h_r};
      end
      plru_pkg::S_EV_CHK: begin
        re    = ev_left != '0;
        raddr = tail[SW-1:0];
      end
      plru_pkg::S_F_RD: begin
        re    = !idx_end && valid[idx[SW-1:0]] && save_on;
        raddr = idx[SW-1:0];
      end
      plru_pkg::S_F_CHK: begin
        we          = rdata.dirty;
        waddr       = idx[SW-1:0];
        wdata.dirty = 1'b0;
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= plru_pkg::S_IDLE;
    else     state <= state_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      head      <= plru_pkg::NIL;
      tail      <= plru_pkg::NIL;
      used      <= '0;
      unp       <= '0;
      out_valid <= 1'b0;
      ret       <= plru_pkg::S_IDLE;
    end else begin
      // raise on a new word, drop once the held word is taken
      if (state == plru_pkg::S_EMIT && out_free) out_valid <= 1'b1;
      else if (out_ready)                         out_valid <= 1'b0;
      case (state)
        plru_pkg::S_G_DECIDE: begin
          if (!hit_found && present_r && free_found) begin
            valid[free_idx] <= 1'b1;
            used            <= used + 1'b1;
          end
          ret <= plru_pkg::S_IDLE;
        end
        plru_pkg::S_REM_P:   if (!(ent.prev < plru_pkg::NIL)) head <= ent.next;
        plru_pkg::S_REM_N:   if (!(ent.next < plru_pkg::NIL)) tail <= ent.prev;
        plru_pkg::S_REM_END: begin
          if (unp != '0) unp <= unp - 1'b1;
          if (mode_r != plru_pkg::MODE_GET) begin
            valid[cur] <= 1'b0;
            if (used != '0) used <= used - 1'b1;
            ret <= plru_pkg::S_EV_CHK;
          end
        end
        plru_pkg::S_ADD_END: begin
          head <= {1'b0, h_r};
          if (!(tail < plru_pkg::NIL)) tail <= {1'b0, h_r};
          unp  <= unp_new;
        end
        plru_pkg::S_IDLE:   ret <= plru_pkg::S_IDLE;
        plru_pkg::S_EV_CHK: ret <= plru_pkg::S_IDLE;
        plru_pkg::S_F_RD:   ret <= idx_end ? plru_pkg::S_IDLE : plru_pkg::S_F_RD;
        default: ;
      endcase
    end
  end

  // datapath and pending result
  always_ff @(posedge clk) begin
    case (state)
      plru_pkg::S_IDLE: begin
        mode_r     <= mode;
        key_r      <= key;
        h_r        <= handle;
        present_r  <= present;
        idx        <= '0;
        chk        <= 1'b0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
        fin_used   <= used;
        fin_unp    <= unp;
        pend       <= '{status: plru_pkg::ST_BAD, slot: handle, key: '0,
                        load: 1'b0, evicted: 1'b0, last: 1'b1};
      end
      plru_pkg::S_G_SCAN: begin
        if (chk && valid[chk_idx] && !hit_found && rdata.key == key_r) begin
          hit_found <= 1'b1;
          hit_idx   <= chk_idx;
          ent       <= rdata;
        end
        if (!idx_end) begin
          if (!valid[idx[SW-1:0]] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx[SW-1:0];
          end
          chk     <= 1'b1;
          chk_idx <= idx[SW-1:0];
          idx     <= idx + 1'b1;
        end else begin
          chk <= 1'b0;
        end
      end
      plru_pkg::S_G_DECIDE: begin
        pend.key <= key_r;
        if (hit_found) begin
          pend.slot   <= hit_idx;
          pend.status <= (ent.pin == plru_pkg::PIN_MAX) ? plru_pkg::ST_OVERFLOW
                                                        : plru_pkg::ST_HIT;
          if (ent.pin == '0) fin_unp <= unp - 1'b1;
        end else if (!present_r) begin
          pend.slot   <= '0;
          pend.status <= plru_pkg::ST_ABSENT;
        end else if (!free_found) begin
          pend.slot   <= '0;
          pend.status <= plru_pkg::ST_FULL;
        end else begin
          pend.status <= plru_pkg::ST_LOADED;
          pend.slot   <= free_idx;
          pend.load   <= 1'b1;
          fin_used    <= used + 1'b1;
        end
      end
      plru_pkg::S_H_CHK: begin
        ent       <= rdata;
        hkey      <= rdata.key;
        pend.slot <= h_r;
        pend.key  <= rdata.key;
        pend.status <= (mode_r == plru_pkg::MODE_RELEASE && rdata.pin == '0)
                       ? plru_pkg::ST_NOTPIN : plru_pkg::ST_DONE;
        if (mode_r == plru_pkg::MODE_RELEASE && rdata.pin != '0 && pin_dec == '0) begin
          ev_left  <= ev_cnt;
          fin_unp  <= unp_new - ev_cnt;
          fin_used <= used - ev_cnt;
        end
      end
      plru_pkg::S_EV_CHK: begin
        pend <= '{status: plru_pkg::ST_DONE, slot: h_r, key: hkey,
                  load: 1'b0, evicted: 1'b0, last: 1'b1};
      end
      plru_pkg::S_EV_RD: begin
        ent <= rdata;
        cur <= tail[SW-1:0];
      end
      plru_pkg::S_REM_END: begin
        if (mode_r != plru_pkg::MODE_GET) begin
          pend <= '{status: (ent.dirty && save_on) ? plru_pkg::ST_WRITEBACK
                                                   : plru_pkg::ST_EVICTED,
                    slot: cur, key: ent.key, load: 1'b0, evicted: 1'b1, last: 1'b0};
          ev_left <= ev_left - 1'b1;
        end
      end
      plru_pkg::S_F_RD: begin
        if (idx_end) begin
          pend <= '{status: plru_pkg::ST_DONE, slot: '0, key: '0,
                    load: 1'b0, evicted: 1'b0, last: 1'b1};
        end else if (!(valid[idx[SW-1:0]] && save_on)) begin
          idx <= idx + 1'b1;
        end
      end
      plru_pkg::S_F_CHK: begin
        pend <= '{status: plru_pkg::ST_WRITEBACK, slot: idx[SW-1:0], key: rdata.key,
                  load: 1'b0, evicted: 1'b0, last: 1'b0};
        idx  <= idx + 1'b1;
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (state == plru_pkg::S_EMIT && out_free) begin
      status         <= pend.status;
      slot           <= pend.slot;
      entry_key      <= pend.key;
      load_request   <= pend.load;
      evicted        <= pend.evicted;
      last           <= pend.last;
      entries_in_use <= fin_used;
      unpinned_count <= fin_unp;
    end
  end

  `PLRU_ASSERT_NOW(a_unp_le_used, 1'b1, unp <= used)
  `PLRU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `PLRU_ASSERT_NOW(a_scan_no_write, state == plru_pkg::S_G_SCAN, !we)
  `PLRU_ASSERT_NOW(a_idle_list, state == plru_pkg::S_IDLE,
                   (head == plru_pkg::NIL) == (unp == '0))

endmodule

FILE: sv/pinned_lru_object_cache.sv
// ----------------------------------------------------------------------------
// pinned_lru_object_cache
// Refcounted LRU slot pool with pinning, dirty marks, eviction and flush.
// ----------------------------------------------------------------------------
// Get: its word follows a slot scan (one store read per slot) and then a list
//   update; release may also evict entries from the LRU tail; flush visits
//   every slot. One item at a time; the next is taken in the cycle after its
//   last word is registered; a held word stalls.
// Reset (synchronous): all slots free, LRU list empty, counts zero,
//   max_unpinned 8, save_enabled 1. No clearing pass is needed.
module pinned_lru_object_cache (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic [plru_pkg::KEY_BITS-1:0] key,
  input  logic [plru_pkg::SLOT_W-1:0]   handle,
  input  logic                          present,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    status,
  output logic [plru_pkg::SLOT_W-1:0]   slot,
  output logic [plru_pkg::KEY_BITS-1:0] entry_key,
  output logic                          load_request,
  output logic                          evicted,
  output logic                          last,
  output logic [plru_pkg::CNT_W-1:0]    entries_in_use,
  output logic [plru_pkg::CNT_W-1:0]    unpinned_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [plru_pkg::MAXU_W-1:0]   cfg_data
);

  plru_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  // take configuration words
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_unpinned <= plru_pkg::MAXU_W'(8);
      cfg.save_enabled <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        plru_pkg::REG_MAX_UNPINNED: cfg.max_unpinned <= cfg_data;
        plru_pkg::REG_SAVE_ENABLED: cfg.save_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  plru_engine u_engine (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .key(key), .handle(handle), .present(present),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .slot(slot), .entry_key(entry_key),
    .load_request(load_request), .evicted(evicted), .last(last),
    .entries_in_use(entries_in_use), .unpinned_count(unpinned_count)
  );

endmodule
